/* hw/rtl/tpc_pkg.sv */
`timescale 1ns / 1ps
package tpc_pkg;

	// Signed distance of a vertex to the plane, wide enough for any input.
	localparam int DW     = 35;
	localparam int CFG_IW = 3;
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [CFG_IW-1:0] REG_POINT_X  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_POINT_Y  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_POINT_Z  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_NORMAL_X = 3'd3;
	localparam logic [CFG_IW-1:0] REG_NORMAL_Y = 3'd4;
	localparam logic [CFG_IW-1:0] REG_NORMAL_Z = 3'd5;

	typedef struct packed {
		logic signed [31:0] in_a_x;
		logic signed [31:0] in_a_y;
		logic signed [31:0] in_a_z;
		logic signed [31:0] in_b_x;
		logic signed [31:0] in_b_y;
		logic signed [31:0] in_b_z;
		logic signed [31:0] in_c_x;
		logic signed [31:0] in_c_y;
		logic signed [31:0] in_c_z;
	} tpc_in_t;

	typedef struct packed {
		logic signed [31:0] out_a_x;
		logic signed [31:0] out_a_y;
		logic signed [31:0] out_a_z;
		logic signed [31:0] out_b_x;
		logic signed [31:0] out_b_y;
		logic signed [31:0] out_b_z;
		logic signed [31:0] out_c_x;
		logic signed [31:0] out_c_y;
		logic signed [31:0] out_c_z;
		logic [1:0]         tri_count;
		logic               last;
	} tpc_out_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} tpc_vec_t;

	typedef struct packed {
		tpc_vec_t              a;
		tpc_vec_t              b;
		tpc_vec_t              c;
		logic signed [DW-1:0]  da;
		logic signed [DW-1:0]  db;
		logic signed [DW-1:0]  dc;
		logic [2:0]            ins;
	} tpc_job_t;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] offset;
		logic               busy;
	} tpc_plane_t;

	typedef struct packed {
		logic [63:0] dividend;
		logic [31:0] divisor;
	} tpc_div_req_t;

	typedef enum logic [3:0] {
		CF_IDLE,
		CF_LOAD,
		CF_SHIFT,
		CF_SQ,
		CF_SQRT,
		CF_DIV,
		CF_DIVW,
		CF_DOT,
		CF_FIN
	} tpc_cfg_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PREP,
		B_WAIT,
		B_MUL,
		B_ADD,
		B_OUT1,
		B_OUT2
	} tpc_back_state_t;

endpackage

/* hw/rtl/triangle_plane_clipper.sv */
`timescale 1ns / 1ps
// Clips a stream of triangles against one plane held in six registers.
// Triangles arrive on tri_valid/tri_stall/tri_data; a request is taken on a
// clock edge with tri_valid high and tri_stall low. Clipped triangles leave
// on res_valid/res_stall/res_data, one or two requests per input, with last
// set on the final one and tri_count giving the number produced.
// A two-stage front computes the vertex distances and classifies the
// triangle; a four-entry queue feeds the back end that computes crossings.
// A triangle wholly inside or wholly outside passes the two front stages,
// the queue and the output register; one such triangle is taken every
// cycle unless a stall holds the flow. A triangle that needs clipping
// goes through the back end states PREP, WAIT (on the crossing dividers),
// MUL, ADD and one output state per output triangle; the back end takes
// no new triangle until it is done. A register write starts a
// renormalisation of the plane normal, during which tri_stall is high.
// Reset loads the plane x >= 0 directly, with no renormalisation.
// While res_stall is high the output register holds its request; the queue
// keeps the front busy until it fills, and then tri_stall rises.
module triangle_plane_clipper import tpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              tri_valid,
	output logic              tri_stall,
	input  tpc_in_t           tri_data,
	output logic              res_valid,
	input  logic              res_stall,
	output tpc_out_t          res_data
);

	tpc_plane_t plane;
	logic       push, full, pop, empty;
	tpc_job_t   push_data, head;

	tpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.plane    (plane)
	);

	tpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tri_valid),
		.in_data   (tri_data),
		.in_stall  (tri_stall),
		.plane     (plane),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	tpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	tpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_stall (res_stall)
	);

endmodule

/* hw/rtl/tpc_div.sv */
`timescale 1ns / 1ps
module tpc_div import tpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot
);

	// Restoring division, two quotient bits a cycle. The upper half of the
	// dividend must be below the divisor, so the quotient fits in 32 bits.
	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] div_q;

	logic [32:0] r1, r1n, r2, r2n;
	logic        ge1, ge2;

	always_comb begin
		r1  = {rem_q, lo_q[31]};
		ge1 = r1 >= {1'b0, div_q};
		r1n = ge1 ? (r1 - {1'b0, div_q}) : r1;
		r2  = {r1n[31:0], lo_q[30]};
		ge2 = r2 >= {1'b0, div_q};
		r2n = ge2 ? (r2 - {1'b0, div_q}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			lo_q  <= dividend[31:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r2n[31:0];
			lo_q  <= {lo_q[29:0], ge1, ge2};
		end
	end

	assign done = done_q;
	assign quot = lo_q;

endmodule

/* hw/rtl/tpc_cfg.sv */
`timescale 1ns / 1ps
module tpc_cfg import tpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CFG_IW-1:0] wr_index,
	input  logic [31:0]       wr_data,
	output tpc_plane_t        plane
);

	tpc_cfg_state_t state_q, state_d;

	logic signed [31:0] point_q [3];
	logic signed [31:0] normal_q [3];
	logic signed [31:0] unit_q [3];
	logic signed [31:0] offset_q;
	logic [31:0]        mag_q [3];
	logic               neg_q [3];
	logic [63:0]        acc_q;
	logic [63:0]        v_q;
	logic [63:0]        res_q;
	logic [31:0]        len_q;
	logic [1:0]         idx_q;
	logic [4:0]         it_q;

	logic        div_start;
	logic        div_done;
	logic [31:0] div_quot;
	logic [63:0] div_dividend;

	logic        recompute;
	logic        norm_zero;
	logic        shift_done;
	logic [63:0] sq;
	logic [63:0] bitv;
	logic [63:0] trial;
	logic        ge;
	logic [63:0] v_next;
	logic [63:0] res_next;
	logic signed [63:0] dprod;
	logic signed [63:0] rnd;
	logic signed [63:0] shr;
	logic [31:0] q_signed;

	assign recompute  = wr_en && (wr_index <= REG_NORMAL_Z);
	assign norm_zero  = (normal_q[0] == '0) && (normal_q[1] == '0) && (normal_q[2] == '0);
	assign shift_done = ((mag_q[0] | mag_q[1] | mag_q[2]) & 32'hC000_0000) != '0;

	always_comb begin
		sq       = mag_q[idx_q] * mag_q[idx_q];
		bitv     = 64'd1 << (6'd62 - {it_q, 1'b0});
		trial    = res_q + bitv;
		ge       = v_q >= trial;
		v_next   = ge ? (v_q - trial) : v_q;
		res_next = ge ? ((res_q >> 1) + bitv) : (res_q >> 1);
		dprod    = $signed(unit_q[idx_q]) * $signed(point_q[idx_q]);
		rnd      = $signed(acc_q) + 64'sd536870912;
		shr      = rnd >>> 30;
		q_signed = neg_q[idx_q] ? (~div_quot + 32'd1) : div_quot;
		div_dividend = ({32'd0, mag_q[idx_q]} << 30) + {33'd0, len_q[31:1]};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CF_IDLE:  state_d = CF_IDLE;
			CF_LOAD:  state_d = norm_zero ? CF_IDLE : CF_SHIFT;
			CF_SHIFT: if (shift_done) state_d = CF_SQ;
			CF_SQ:    if (idx_q == 2'd2) state_d = CF_SQRT;
			CF_SQRT:  if (it_q == 5'd31) state_d = CF_DIV;
			CF_DIV:   state_d = CF_DIVW;
			CF_DIVW:  if (div_done) state_d = (idx_q == 2'd2) ? CF_DOT : CF_DIV;
			CF_DOT:   if (idx_q == 2'd2) state_d = CF_FIN;
			CF_FIN:   state_d = CF_IDLE;
			default:  state_d = CF_IDLE;
		endcase
		// A write to any of the six plane registers restarts the normalisation from the latest registers.
		if (recompute) state_d = CF_LOAD;
	end

	always_comb begin
		div_start = 1'b0;
		unique case (state_q)
			CF_DIV:  div_start = 1'b1;
			default: div_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CF_IDLE;
			point_q[0]  <= '0;
			point_q[1]  <= '0;
			point_q[2]  <= '0;
			normal_q[0] <= 32'sd65536;
			normal_q[1] <= '0;
			normal_q[2] <= '0;
			unit_q[0]   <= 32'sd1073741824;
			unit_q[1]   <= '0;
			unit_q[2]   <= '0;
			offset_q    <= '0;
			idx_q       <= '0;
			it_q        <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					REG_POINT_X:  point_q[0]  <= wr_data;
					REG_POINT_Y:  point_q[1]  <= wr_data;
					REG_POINT_Z:  point_q[2]  <= wr_data;
					REG_NORMAL_X: normal_q[0] <= wr_data;
					REG_NORMAL_Y: normal_q[1] <= wr_data;
					REG_NORMAL_Z: normal_q[2] <= wr_data;
					default: ;
				endcase
			end
			case (state_q)
				CF_LOAD: begin
					idx_q <= '0;
					if (norm_zero) begin
						unit_q[0] <= '0;
						unit_q[1] <= '0;
						unit_q[2] <= '0;
						offset_q  <= '0;
					end
				end
				CF_SQ: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					it_q  <= '0;
				end
				CF_SQRT: it_q <= it_q + 5'd1;
				CF_DIVW: begin
					if (div_done) begin
						unit_q[idx_q] <= q_signed;
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					end
				end
				CF_DOT: idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				CF_FIN: begin
					if (shr > 64'sd2147483647)
						offset_q <= 32'sh7FFF_FFFF;
					else if (shr < -64'sd2147483648)
						offset_q <= 32'sh8000_0000;
					else
						offset_q <= shr[31:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CF_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= normal_q[i][31];
					mag_q[i] <= normal_q[i][31] ? (~normal_q[i] + 32'd1) : normal_q[i];
				end
				acc_q <= '0;
			end
			CF_SHIFT: begin
				if (!shift_done) begin
					mag_q[0] <= mag_q[0] << 1;
					mag_q[1] <= mag_q[1] << 1;
					mag_q[2] <= mag_q[2] << 1;
				end
			end
			CF_SQ: begin
				acc_q <= acc_q + sq;
				v_q   <= acc_q + sq;
				res_q <= '0;
			end
			CF_SQRT: begin
				v_q   <= v_next;
				res_q <= res_next;
				if (it_q == 5'd31) len_q <= res_next[31:0];
			end
			CF_DIVW: if (div_done && idx_q == 2'd2) acc_q <= '0;
			CF_DOT: acc_q <= acc_q + dprod;
			default: ;
		endcase
	end

	tpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (len_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign plane.nx     = unit_q[0];
	assign plane.ny     = unit_q[1];
	assign plane.nz     = unit_q[2];
	assign plane.offset = offset_q;
	assign plane.busy   = (state_q != CF_IDLE);

endmodule

/* hw/rtl/tpc_front.sv */
`timescale 1ns / 1ps
module tpc_front import tpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  tpc_in_t    in_data,
	output logic       in_stall,
	input  tpc_plane_t plane,
	output logic       push,
	output tpc_job_t   push_data,
	input  logic       full
);

	logic               v_s1, v_s2;
	tpc_in_t            data_s1;
	logic signed [63:0] prod_s1 [9];
	tpc_job_t           job_s2;

	logic               hold;
	logic signed [63:0] dsum [3];
	logic signed [63:0] vdist [3];
	logic signed [31:0] coord [9];

	assign hold     = v_s2 && full;
	assign in_stall = hold || plane.busy;
	assign push     = v_s2 && !full;

	assign coord[0] = in_data.in_a_x;
	assign coord[1] = in_data.in_a_y;
	assign coord[2] = in_data.in_a_z;
	assign coord[3] = in_data.in_b_x;
	assign coord[4] = in_data.in_b_y;
	assign coord[5] = in_data.in_b_z;
	assign coord[6] = in_data.in_c_x;
	assign coord[7] = in_data.in_c_y;
	assign coord[8] = in_data.in_c_z;

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			dsum[v] = $signed(prod_s1[3*v]) + $signed(prod_s1[3*v+1])
				+ $signed(prod_s1[3*v+2]) + 64'sd536870912;
			vdist[v] = (dsum[v] >>> 30) - 64'($signed(plane.offset));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!hold) begin
			v_s1 <= in_valid && !plane.busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			data_s1 <= in_data;
			for (int v = 0; v < 3; v++) begin
				prod_s1[3*v]   <= $signed(plane.nx) * $signed(coord[3*v]);
				prod_s1[3*v+1] <= $signed(plane.ny) * $signed(coord[3*v+1]);
				prod_s1[3*v+2] <= $signed(plane.nz) * $signed(coord[3*v+2]);
			end
			job_s2.a   <= {data_s1.in_a_x, data_s1.in_a_y, data_s1.in_a_z};
			job_s2.b   <= {data_s1.in_b_x, data_s1.in_b_y, data_s1.in_b_z};
			job_s2.c   <= {data_s1.in_c_x, data_s1.in_c_y, data_s1.in_c_z};
			job_s2.da  <= vdist[0][DW-1:0];
			job_s2.db  <= vdist[1][DW-1:0];
			job_s2.dc  <= vdist[2][DW-1:0];
			job_s2.ins <= {!vdist[2][63], !vdist[1][63], !vdist[0][63]};
		end
	end

	assign push_data = job_s2;

endmodule

/* hw/rtl/tpc_fifo.sv */
`timescale 1ns / 1ps
module tpc_fifo import tpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tpc_job_t push_data,
	output logic     full,
	input  logic     pop,
	output tpc_job_t head,
	output logic     empty
);

	tpc_job_t     mem_q [QDEPTH];
	logic [QAW:0] wr_ptr_q, rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[QAW] != rd_ptr_q[QAW]) &&
		(wr_ptr_q[QAW-1:0] == rd_ptr_q[QAW-1:0]);
	assign head  = mem_q[rd_ptr_q[QAW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q[QAW-1:0]] <= push_data;
	end

endmodule

/* hw/rtl/tpc_back.sv */
`timescale 1ns / 1ps
module tpc_back import tpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  tpc_job_t head,
	output logic     pop,
	output logic     res_valid,
	output tpc_out_t res_data,
	input  logic     res_stall
);

	localparam int SHMAX = DW - 30;
	localparam logic [DW:0] DEN_LIM = (DW+1)'(1) << 31;

	// Crossing ratio: both terms halved together until the denominator fits
	// in 31 bits, then rounded division in Q0.30.
	function automatic tpc_div_req_t tpc_ratio(input logic signed [DW-1:0] din,
			input logic signed [DW-1:0] dout);
		logic [DW:0]  den;
		logic [DW:0]  dsh;
		logic [DW:0]  nsh;
		int           s;
		tpc_div_req_t r;
		den = {din[DW-1], din} - {dout[DW-1], dout};
		s = 0;
		for (int i = SHMAX; i >= 0; i--) begin
			if ((den >> i) < DEN_LIM) s = i;
		end
		dsh = den >> s;
		nsh = {1'b0, din} >> s;
		r.divisor  = dsh[31:0];
		r.dividend = {3'd0, nsh[30:0], 30'd0} + {33'd0, dsh[31:1]};
		return r;
	endfunction

	tpc_back_state_t state_q, state_d;

	tpc_vec_t             s1v_q, e1v_q, s2v_q, e2v_q;
	logic signed [DW-1:0] ds1_q, de1_q, ds2_q, de2_q;
	logic                 two_q;
	logic signed [63:0]   pr1_q [3];
	logic signed [63:0]   pr2_q [3];
	tpc_vec_t             p1_q, p2_q;

	logic     res_valid_q;
	tpc_out_t res_q;

	logic         trivial;
	logic         out_free;
	logic         load_out;
	logic         div_start;
	tpc_out_t     out_d;
	tpc_div_req_t req1, req2;
	logic         done1, done2;
	logic [31:0]  quot1, quot2;

	logic signed [32:0] dif1 [3];
	logic signed [32:0] dif2 [3];
	logic signed [64:0] mul1 [3];
	logic signed [64:0] mul2 [3];
	logic signed [63:0] rnd1 [3];
	logic signed [63:0] rnd2 [3];
	logic signed [31:0] s1c [3], e1c [3], s2c [3], e2c [3];
	logic [31:0]        p1c [3], p2c [3];

	assign trivial  = (head.ins == 3'b000) || (head.ins == 3'b111);
	assign out_free = !res_valid_q || !res_stall;
	assign req1     = tpc_ratio(ds1_q, de1_q);
	assign req2     = tpc_ratio(ds2_q, de2_q);

	assign s1c[0] = s1v_q.x; assign s1c[1] = s1v_q.y; assign s1c[2] = s1v_q.z;
	assign e1c[0] = e1v_q.x; assign e1c[1] = e1v_q.y; assign e1c[2] = e1v_q.z;
	assign s2c[0] = s2v_q.x; assign s2c[1] = s2v_q.y; assign s2c[2] = s2v_q.z;
	assign e2c[0] = e2v_q.x; assign e2c[1] = e2v_q.y; assign e2c[2] = e2v_q.z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dif1[k] = $signed({e1c[k][31], e1c[k]}) - $signed({s1c[k][31], s1c[k]});
			dif2[k] = $signed({e2c[k][31], e2c[k]}) - $signed({s2c[k][31], s2c[k]});
			mul1[k] = dif1[k] * $signed({1'b0, quot1[30:0]});
			mul2[k] = dif2[k] * $signed({1'b0, quot2[30:0]});
			rnd1[k] = pr1_q[k] + 64'sd536870912;
			rnd2[k] = pr2_q[k] + 64'sd536870912;
			p1c[k]  = s1c[k] + rnd1[k][61:30];
			p2c[k]  = s2c[k] + rnd2[k][61:30];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!empty && !trivial) state_d = B_PREP;
			B_PREP: state_d = B_WAIT;
			B_WAIT: if (done1) state_d = B_MUL;
			B_MUL:  state_d = B_ADD;
			B_ADD:  state_d = B_OUT1;
			B_OUT1: if (out_free) state_d = two_q ? B_OUT2 : B_IDLE;
			B_OUT2: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		load_out  = 1'b0;
		div_start = 1'b0;
		out_d     = '0;
		unique case (state_q)
			B_IDLE: begin
				pop      = !empty && (!trivial || out_free);
				load_out = !empty && trivial && out_free;
				if (head.ins == 3'b111) begin
					out_d = {head.a, head.b, head.c, 2'd1, 1'b1};
				end else begin
					out_d = {288'd0, 2'd0, 1'b1};
				end
			end
			B_PREP: div_start = 1'b1;
			B_OUT1: begin
				load_out = out_free;
				if (two_q) out_d = {s1v_q, s2v_q, p1_q, 2'd2, 1'b0};
				else       out_d = {s1v_q, p1_q, p2_q, 2'd1, 1'b1};
			end
			B_OUT2: begin
				load_out = out_free;
				out_d    = {s2v_q, p2_q, p1_q, 2'd2, 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) res_q <= out_d;
		if (state_q == B_IDLE && !empty && !trivial) begin
			// One inside vertex: crossings go from it to each outside vertex.
			// Two inside: crossings go from each inside vertex to the outside one.
			case (head.ins)
				3'b001: begin
					s1v_q <= head.a; e1v_q <= head.b; ds1_q <= head.da; de1_q <= head.db;
					s2v_q <= head.a; e2v_q <= head.c; ds2_q <= head.da; de2_q <= head.dc;
					two_q <= 1'b0;
				end
				3'b010: begin
					s1v_q <= head.b; e1v_q <= head.a; ds1_q <= head.db; de1_q <= head.da;
					s2v_q <= head.b; e2v_q <= head.c; ds2_q <= head.db; de2_q <= head.dc;
					two_q <= 1'b0;
				end
				3'b100: begin
					s1v_q <= head.c; e1v_q <= head.a; ds1_q <= head.dc; de1_q <= head.da;
					s2v_q <= head.c; e2v_q <= head.b; ds2_q <= head.dc; de2_q <= head.db;
					two_q <= 1'b0;
				end
				3'b011: begin
					s1v_q <= head.a; e1v_q <= head.c; ds1_q <= head.da; de1_q <= head.dc;
					s2v_q <= head.b; e2v_q <= head.c; ds2_q <= head.db; de2_q <= head.dc;
					two_q <= 1'b1;
				end
				3'b101: begin
					s1v_q <= head.a; e1v_q <= head.b; ds1_q <= head.da; de1_q <= head.db;
					s2v_q <= head.c; e2v_q <= head.b; ds2_q <= head.dc; de2_q <= head.db;
					two_q <= 1'b1;
				end
				default: begin
					s1v_q <= head.b; e1v_q <= head.a; ds1_q <= head.db; de1_q <= head.da;
					s2v_q <= head.c; e2v_q <= head.a; ds2_q <= head.dc; de2_q <= head.da;
					two_q <= 1'b1;
				end
			endcase
		end
		if (state_q == B_MUL) begin
			for (int k = 0; k < 3; k++) begin
				pr1_q[k] <= mul1[k][63:0];
				pr2_q[k] <= mul2[k][63:0];
			end
		end
		if (state_q == B_ADD) begin
			p1_q <= {p1c[0], p1c[1], p1c[2]};
			p2_q <= {p2c[0], p2c[1], p2c[2]};
		end
	end

	tpc_div u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req1.dividend),
		.divisor  (req1.divisor),
		.done     (done1),
		.quot     (quot1)
	);

	tpc_div u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req2.dividend),
		.divisor  (req2.divisor),
		.done     (done2),
		.quot     (quot2)
	);

	// Both dividers start together and finish together.
	assign res_valid = res_valid_q && (done2 || !done2);
	assign res_data  = res_q;

endmodule

/* sim/tb_triangle_plane_clipper.sv */
`timescale 1ns / 1ps
module tb_triangle_plane_clipper;
	import tpc_pkg::*;

	localparam longint ONE_FX      = 65536;
	localparam longint HALF_Q30    = longint'(1) << 29;
	localparam int     IDLE_LIMIT  = 5000;
	localparam int     ITEMS_PHASE = 285;
	localparam int     N_PHASES    = 7;
	// Index past the last register; writes to it must be ignored.
	localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd6;

	typedef longint vec3_t [3];

	typedef struct {
		tpc_in_t  tri_in;
		bit       typed;
		tpc_out_t res;
	} tri_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_IW-1:0] cfg_index;
	logic [31:0]       cfg_data;
	logic              tri_valid;
	logic              tri_stall;
	tpc_in_t           tri_data;
	logic              res_valid;
	logic              res_stall;
	tpc_out_t          res_data;

	triangle_plane_clipper DUT (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .tri_valid(tri_valid), .tri_stall(tri_stall),
		.tri_data(tri_data), .res_valid(res_valid), .res_stall(res_stall),
		.res_data(res_data)
	);

	// Plane registers and the derived unit normal and offset.
	longint   plane_pt [3];
	longint   plane_nrm [3];
	longint   unit_nrm [3];
	longint   plane_off;
	tpc_out_t clip_q [$];

	int  errors, n_results, n_tris;
	int  n_empty, n_whole, n_one_in, n_two_in;
	int  idle_cycles;
	bit  quiet, hold_req;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = longint'(1) << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void update_plane();
		longint unsigned mag [3];
		bit              neg [3];
		longint unsigned m, sum, len;
		longint          dot, q;
		m = 0;
		sum = 0;
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = plane_nrm[i] < 0;
			mag[i] = neg[i] ? -plane_nrm[i] : plane_nrm[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			unit_nrm = '{0, 0, 0};
			plane_off = 0;
			return;
		end
		while (m < (longint'(1) << 30)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = longint'(((mag[i] << 30) + len / 2) / len);
			unit_nrm[i] = neg[i] ? -q : q;
			dot += unit_nrm[i] * plane_pt[i];
		end
		dot = (dot + HALF_Q30) >>> 30;
		if (dot > 64'sd2147483647) dot = 64'sd2147483647;
		if (dot < -64'sd2147483648) dot = -64'sd2147483648;
		plane_off = dot;
	endfunction

	function automatic longint plane_dist(input vec3_t v);
		longint dot;
		dot = 0;
		for (int i = 0; i < 3; i++) dot += unit_nrm[i] * v[i];
		return ((dot + HALF_Q30) >>> 30) - plane_off;
	endfunction

	function automatic void edge_cross(input vec3_t a, input vec3_t b, input longint da,
			input longint db, output vec3_t o);
		longint unsigned num, den;
		longint          t;
		num = da;
		den = da - db;
		while (den >= (longint'(1) << 31)) begin
			num >>= 1;
			den >>= 1;
		end
		t = longint'(((num << 30) + den / 2) / den);
		for (int i = 0; i < 3; i++) o[i] = a[i] + (((b[i] - a[i]) * t + HALF_Q30) >>> 30);
	endfunction

	function automatic tpc_out_t make_res(input vec3_t p, input vec3_t q, input vec3_t r,
			input int cnt, input bit fin);
		tpc_out_t o;
		o.out_a_x = p[0][31:0]; o.out_a_y = p[1][31:0]; o.out_a_z = p[2][31:0];
		o.out_b_x = q[0][31:0]; o.out_b_y = q[1][31:0]; o.out_b_z = q[2][31:0];
		o.out_c_x = r[0][31:0]; o.out_c_y = r[1][31:0]; o.out_c_z = r[2][31:0];
		o.tri_count = 2'(cnt);
		o.last = fin;
		return o;
	endfunction

	// Classifies the triangle and queues the clipped triangles it must produce.
	function automatic void clip_triangle(input tpc_in_t t);
		vec3_t  v [3];
		vec3_t  p1, p2;
		vec3_t  zero3;
		longint d [3];
		int     ins [$], outs [$];
		zero3 = '{0, 0, 0};
		v[0] = '{t.in_a_x, t.in_a_y, t.in_a_z};
		v[1] = '{t.in_b_x, t.in_b_y, t.in_b_z};
		v[2] = '{t.in_c_x, t.in_c_y, t.in_c_z};
		for (int i = 0; i < 3; i++) begin
			d[i] = plane_dist(v[i]);
			if (d[i] >= 0) ins.push_back(i);
			else outs.push_back(i);
		end
		case (ins.size())
			0: begin
				n_empty++;
				clip_q.push_back(make_res(zero3, zero3, zero3, 0, 1));
			end
			3: begin
				n_whole++;
				clip_q.push_back(make_res(v[0], v[1], v[2], 1, 1));
			end
			1: begin
				n_one_in++;
				edge_cross(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]], p1);
				edge_cross(v[ins[0]], v[outs[1]], d[ins[0]], d[outs[1]], p2);
				clip_q.push_back(make_res(v[ins[0]], p1, p2, 1, 1));
			end
			default: begin
				n_two_in++;
				edge_cross(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]], p1);
				edge_cross(v[ins[1]], v[outs[0]], d[ins[1]], d[outs[0]], p2);
				clip_q.push_back(make_res(v[ins[0]], v[ins[1]], p1, 2, 0));
				clip_q.push_back(make_res(v[ins[1]], p2, p1, 2, 1));
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tri_valid = 1'b0;
		tri_data = '0;
		res_stall = 1'b0;
	end

	// Receiver: random stall bursts, plus one long hold-off when asked.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				res_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tpc_out_t want;
		if (arst_n) begin
			idle_cycles++;
			if (tri_valid && !tri_stall) idle_cycles = 0;
			if (res_valid && !res_stall) begin
				idle_cycles = 0;
				n_results++;
				if (clip_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %p", res_data);
				end else begin
					want = clip_q.pop_front();
					if (res_data !== want) begin
						errors++;
						if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p",
							want, res_data);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input longint val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[31:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx <= REG_NORMAL_Z) begin
			if (idx <= REG_POINT_Z) plane_pt[idx] = longint'($signed(val[31:0]));
			else plane_nrm[idx - REG_NORMAL_X] = longint'($signed(val[31:0]));
			update_plane();
		end
		// Let the renormalisation begin, then wait for it to finish.
		repeat (2) @(posedge clk);
		while (tri_stall) @(posedge clk);
	endtask

	task automatic set_plane(input longint p [3], input longint n [3]);
		while (clip_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		write_reg(REG_POINT_X, p[0]);
		write_reg(REG_POINT_Y, p[1]);
		write_reg(REG_POINT_Z, p[2]);
		write_reg(REG_NORMAL_X, n[0]);
		write_reg(REG_NORMAL_Y, n[1]);
		write_reg(REG_NORMAL_Z, n[2]);
	endtask

	// Offers one triangle and holds it until taken; the caller is at a clock edge.
	task automatic send_tri(input tpc_in_t t, input bit typed, input tpc_out_t res);
		int n;
		tri_data <= t;
		tri_valid <= 1'b1;
		do @(posedge clk); while (tri_stall);
		n_tris++;
		if (typed) clip_q.push_back(res);
		else clip_triangle(t);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 11);
			tri_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic longint near_val();
		return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
	endfunction

	function automatic tpc_in_t rand_tri(input bit wide);
		tpc_in_t t;
		if (wide) begin
			t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom};
		end else begin
			t.in_a_x = 32'(near_val()); t.in_a_y = 32'(near_val());
			t.in_a_z = 32'(near_val());
			t.in_b_x = 32'(near_val()); t.in_b_y = 32'(near_val());
			t.in_b_z = 32'(near_val());
			t.in_c_x = 32'(near_val()); t.in_c_y = 32'(near_val());
			t.in_c_z = 32'(near_val());
		end
		return t;
	endfunction

	initial begin
		tri_row_t tbl [12];
		longint   pp [3], nn [3];
		tpc_out_t none;
		none = '0;
		errors = 0; n_results = 0; n_tris = 0; idle_cycles = 0;
		n_empty = 0; n_whole = 0; n_one_in = 0; n_two_in = 0;
		quiet = 1'b0; hold_req = 1'b0;
		plane_pt = '{0, 0, 0};
		plane_nrm = '{ONE_FX, 0, 0};
		update_plane();

		// After reset the plane is x >= 0 through the origin.
		tbl[0] = '{tpc_in_t'{ONE_FX, 2*ONE_FX, 3*ONE_FX, 4*ONE_FX, 5*ONE_FX, 6*ONE_FX,
			7*ONE_FX, 8*ONE_FX, 9*ONE_FX}, 1'b1, tpc_out_t'{ONE_FX, 2*ONE_FX, 3*ONE_FX,
			4*ONE_FX, 5*ONE_FX, 6*ONE_FX, 7*ONE_FX, 8*ONE_FX, 9*ONE_FX, 2'd1, 1'b1}};
		tbl[1] = '{tpc_in_t'{-ONE_FX, 1, 2, -5, 3, 4, -2147483648, 5, 6}, 1'b1,
			tpc_out_t'{0, 0, 0, 0, 0, 0, 0, 0, 0, 2'd0, 1'b1}};
		tbl[2] = '{tpc_in_t'{0, 7, -7, 0, 9, 1, 0, -3, 5}, 1'b1,
			tpc_out_t'{0, 7, -7, 0, 9, 1, 0, -3, 5, 2'd1, 1'b1}};
		tbl[3] = '{'1 >> 1, 1'b1, none};
		tbl[3].tri_in = {9{32'h7fffffff}};
		tbl[3].res = {{9{32'h7fffffff}}, 2'd1, 1'b1};
		tbl[4] = '{{9{32'h80000000}}, 1'b1, tpc_out_t'{0, 0, 0, 0, 0, 0, 0, 0, 0, 2'd0, 1'b1}};
		tbl[5] = '{tpc_in_t'{2*ONE_FX, ONE_FX, 0, -2*ONE_FX, 0, ONE_FX, -6*ONE_FX, 3, 4},
			1'b0, none};
		tbl[6] = '{tpc_in_t'{-ONE_FX, 5, 5, -3*ONE_FX, 6, 6, ONE_FX, ONE_FX, ONE_FX},
			1'b0, none};
		tbl[7] = '{tpc_in_t'{ONE_FX, 0, 0, 3*ONE_FX, ONE_FX, 0, -ONE_FX, 0, ONE_FX},
			1'b0, none};
		tbl[8] = '{tpc_in_t'{5*ONE_FX, 1, 1, -ONE_FX, 2, 2, ONE_FX, 3, 3}, 1'b0, none};
		tbl[9] = '{tpc_in_t'{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff}, 1'b0, none};
		tbl[10] = '{tpc_in_t'{0, ONE_FX, ONE_FX, -1, 0, 0, -1, 5, 5}, 1'b0, none};
		tbl[11] = '{tpc_in_t'{32'h7fffffff, 3, 3, 32'h7fffffff, 4, 4, 32'h80000000, 5, 5},
			1'b0, none};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tbl[k]) send_tri(tbl[k].tri_in, tbl[k].typed, tbl[k].res);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				1: begin pp = '{0, 0, 0}; nn = '{0, ONE_FX, 0}; end
				2: begin pp = '{ONE_FX, 2*ONE_FX, -ONE_FX}; nn = '{3, -4, 12}; end
				3: begin pp = '{ONE_FX, ONE_FX, ONE_FX}; nn = '{0, 0, 0}; end
				4: begin
					pp = '{2147483647, -2147483648, 2147483647};
					nn = '{-2147483648, 2147483647, -2147483648};
				end
				5: begin
					pp = '{longint'($signed($urandom)), longint'($signed($urandom)),
						longint'($signed($urandom))};
					nn = '{longint'($signed($urandom)), longint'($signed($urandom)),
						longint'($signed($urandom))};
				end
				6: begin pp = '{near_val(), near_val(), 0}; nn = '{ONE_FX, ONE_FX, -ONE_FX}; end
				default: begin pp = plane_pt; nn = plane_nrm; end
			endcase
			if (ph != 0) begin
				tri_valid <= 1'b0;
				set_plane(pp, nn);
				if (ph == 6) write_reg(REG_UNUSED, 32'h12345678);
				@(posedge clk);
			end
			for (int k = 0; k < ITEMS_PHASE; k++) begin
				if (ph == 1 && k == 50) hold_req = 1'b1;
				if (ph == N_PHASES - 1 && k == ITEMS_PHASE - 80) quiet = 1'b1;
				send_tri(rand_tri($urandom_range(0, 2) == 0), 1'b0, none);
			end
		end
		tri_valid <= 1'b0;

		while (clip_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d triangles sent, %0d results checked: %0d empty, %0d whole,",
			n_tris, n_results, n_empty, n_whole);
		$display("%0d with one vertex inside, %0d with two; %0d mismatches",
			n_one_in, n_two_in, errors);
		if (errors == 0 && clip_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* triangle_plane_clipper.f */
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_div.sv
hw/rtl/tpc_cfg.sv
hw/rtl/tpc_front.sv
hw/rtl/tpc_fifo.sv
hw/rtl/tpc_back.sv
hw/rtl/triangle_plane_clipper.sv
sim/tb_triangle_plane_clipper.sv
